// ===== src/bmp_pixel_array_to_framebuffer_unit_defines.svh =====
`ifndef BMP_PIXEL_ARRAY_TO_FRAMEBUFFER_UNIT_DEFINES_SVH
`define BMP_PIXEL_ARRAY_TO_FRAMEBUFFER_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define BPFB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define BPFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bpfb_pkg.sv =====
package bpfb_pkg;

   localparam int unsigned FB_ADDR_W = 19;
   localparam int unsigned COLOR_W   = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned COORD_W   = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_IMAGE_WIDTH   = 3'd2,
      CSR_IMAGE_HEIGHT  = 3'd3,
      CSR_ALPHA_PRESENT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_BLUE  = 2'd0,
      PHASE_GREEN = 2'd1,
      PHASE_RED   = 2'd2,
      PHASE_ALPHA = 2'd3
   } phase_type;

   typedef struct packed {
      logic [FB_ADDR_W-1:0] fb_address;
      logic                 on_screen;
   } locate_type;

endpackage

// ===== src/bpfb_locate.sv =====
module bpfb_locate #(
   parameter int unsigned PANEL_WIDTH  = 800,
   parameter int unsigned PANEL_HEIGHT = 480
) (
   input  logic [11:0]          origin_x,
   input  logic [11:0]          origin_y,
   input  logic [11:0]          image_height,
   input  logic [10:0]          column,
   input  logic [10:0]          row,
   output bpfb_pkg::locate_type loc
);

   localparam int unsigned CW = bpfb_pkg::COORD_W;
   localparam int unsigned PW = 22;

   logic signed [CW-1:0] sx;
   logic signed [CW-1:0] sy;
   logic signed [CW-1:0] height_s;
   logic                 vis;
   logic [PW-1:0]        addr_full;

   assign height_s = CW'($signed(image_height));
   assign sx = CW'($signed(origin_x)) + $signed(CW'(column));

   always_comb begin
      if (height_s > 0) begin
         sy = CW'($signed(origin_y)) + height_s - CW'(1) - $signed(CW'(row));
      end else begin
         sy = CW'($signed(origin_y)) + $signed(CW'(row));
      end
   end

   assign vis = (sx >= 0) && (sx < $signed(CW'(PANEL_WIDTH)))
             && (sy >= 0) && (sy < $signed(CW'(PANEL_HEIGHT)));

   assign addr_full = PW'(sy[10:0]) * PW'(PANEL_WIDTH) + PW'(sx[10:0]);

   assign loc.on_screen  = vis;
   assign loc.fb_address = vis ? addr_full[bpfb_pkg::FB_ADDR_W-1:0] : '0;

endmodule

// ===== src/bmp_pixel_array_to_framebuffer_unit.sv =====
// Unpacks a BMP pixel array fed one byte per beat on req_ (blue, green, red and, when
// alpha_present is set, alpha; 24-bit rows skip their padding to four bytes) and emits one
// beat per pixel on rsp_ with its framebuffer address (screen y*PANEL_WIDTH+x, zero
// off-screen), ARGB colour, an on-screen flag in tuser and the final-pixel flag in tlast.
// One byte is taken per cycle while the output register is free or being drained; a pixel's
// result appears in the output register the cycle after its last byte. After the final
// pixel every byte is swallowed until reset. Program the csr_ registers only while idle.
`include "bmp_pixel_array_to_framebuffer_unit_defines.svh"

module bmp_pixel_array_to_framebuffer_unit #(
   parameter int unsigned PANEL_WIDTH  = 800,
   parameter int unsigned PANEL_HEIGHT = 480
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // fb_address[18:0], pixel_color[50:19], zero fill
   output logic        rsp_tuser,   // on_screen
   output logic        rsp_tlast,   // last_pixel
   input  logic        csr_we,
   input  logic [bpfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpfb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [11:0] origin_x_ff;
   logic [11:0] origin_y_ff;
   logic [10:0] image_width_ff;
   logic [11:0] image_height_ff;
   logic        alpha_present_ff;

   bpfb_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  blue_ff, blue_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  red_ff, red_in;
   logic [10:0] column_ff, column_in;
   logic [10:0] row_ff, row_in;
   logic [1:0]  pad_ff, pad_in;
   logic        done_ff, done_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [bpfb_pkg::FB_ADDR_W-1:0] addr_ff;
   logic [bpfb_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic        on_screen_ff;
   logic        last_ff, last_in;

   logic        take;
   logic        active;
   logic        emit;
   logic [7:0]  alpha_val;
   logic [11:0] height_mag;
   logic [10:0] rows;
   logic        row_end;
   bpfb_pkg::locate_type loc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         image_width_ff   <= 11'd1;
         image_height_ff  <= 12'd1;
         alpha_present_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            bpfb_pkg::CSR_ORIGIN_X:      origin_x_ff      <= csr_wdata;
            bpfb_pkg::CSR_ORIGIN_Y:      origin_y_ff      <= csr_wdata;
            bpfb_pkg::CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[10:0];
            bpfb_pkg::CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            bpfb_pkg::CSR_ALPHA_PRESENT: alpha_present_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // row count from signed height, -2048 clamps to 2047
   assign height_mag = image_height_ff[11] ? (~image_height_ff + 12'd1) : image_height_ff;
   assign rows       = height_mag[11] ? 11'h7FF : height_mag[10:0];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign active     = !done_ff && (rows != '0) && (image_width_ff != '0);
   assign row_end    = ({1'b0, column_ff} + 12'd1) >= {1'b0, image_width_ff};

   always_comb begin
      phase_in  = phase_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      red_in    = red_ff;
      column_in = column_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;
      done_in   = done_ff;
      emit      = 1'b0;
      alpha_val = '0;
      last_in   = 1'b0;
      if (take && active) begin
         if (pad_ff != '0) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            unique case (phase_ff)
               bpfb_pkg::PHASE_BLUE: begin
                  blue_in  = req_tdata;
                  phase_in = bpfb_pkg::PHASE_GREEN;
               end
               bpfb_pkg::PHASE_GREEN: begin
                  green_in = req_tdata;
                  phase_in = bpfb_pkg::PHASE_RED;
               end
               bpfb_pkg::PHASE_RED: begin
                  red_in = req_tdata;
                  if (alpha_present_ff) begin
                     phase_in = bpfb_pkg::PHASE_ALPHA;
                  end else begin
                     emit = 1'b1;
                  end
               end
               bpfb_pkg::PHASE_ALPHA: begin
                  emit      = 1'b1;
                  alpha_val = alpha_present_ff ? req_tdata : 8'd0;
               end
            endcase
            if (emit) begin
               phase_in = bpfb_pkg::PHASE_BLUE;
               last_in  = row_end && (({1'b0, row_ff} + 12'd1) >= {1'b0, rows});
               if (last_in) begin
                  done_in = 1'b1;
               end else if (row_end) begin
                  column_in = '0;
                  row_in    = row_ff + 11'd1;
                  if (!alpha_present_ff) begin
                     pad_in = image_width_ff[1:0];
                  end
               end else begin
                  column_in = column_ff + 11'd1;
               end
            end
         end
      end
   end

   assign color_in = {alpha_val, red_in, green_in, blue_in};

   bpfb_locate #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_locate (
      .origin_x    (origin_x_ff),
      .origin_y    (origin_y_ff),
      .image_height(image_height_ff),
      .column      (column_ff),
      .row         (row_ff),
      .loc         (loc)
   );

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bpfb_pkg::PHASE_BLUE;
         blue_ff      <= '0;
         green_ff     <= '0;
         red_ff       <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         pad_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         blue_ff      <= blue_in;
         green_ff     <= green_in;
         red_ff       <= red_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         pad_ff       <= pad_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (emit) begin
         addr_ff      <= loc.fb_address;
         color_ff     <= color_in;
         on_screen_ff <= loc.on_screen;
         last_ff      <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, color_ff, addr_ff};
   assign rsp_tuser  = on_screen_ff;
   assign rsp_tlast  = last_ff;

   `BPFB_ASSERT_SAME(a_offscreen_addr_zero, clock, reset,
      rsp_valid_ff && !on_screen_ff, addr_ff == '0, "off-screen pixel with nonzero address")
   `BPFB_ASSERT_SAME(a_addr_in_panel, clock, reset,
      rsp_valid_ff && on_screen_ff,
      32'(addr_ff) < 32'(PANEL_WIDTH * PANEL_HEIGHT), "address beyond panel")
   `BPFB_ASSERT_SAME(a_pad_on_boundary, clock, reset,
      pad_ff != '0, phase_ff == bpfb_pkg::PHASE_BLUE, "padding skipped mid-pixel")
   `BPFB_ASSERT_NEXT(a_last_sets_done, clock, reset,
      emit && last_in, done_ff, "final pixel did not end the image")
   `BPFB_ASSERT_NEXT(a_done_is_silent, clock, reset,
      done_ff && !rsp_valid_ff, !rsp_valid_ff, "beat after final pixel")

endmodule

// ===== bench/bmp_unpack_checker.sv =====
module bmp_unpack_checker #(
   parameter int PANEL_W = 800,
   parameter int PANEL_H = 480
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [bpfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpfb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [bpfb_pkg::FB_ADDR_W-1:0] addr;
      logic [bpfb_pkg::COLOR_W-1:0]   color;
      logic                           on_screen;
      logic                           last;
   } pixel_out_type;

   logic [11:0] org_x, org_y, img_h;
   logic [10:0] img_w;
   logic        alpha_en;

   bpfb_pkg::phase_type phase;
   logic [7:0]  blue_b, green_b, red_b;
   logic [10:0] col, row;
   logic [1:0]  pad_left;
   logic        image_done;

   pixel_out_type pending_pixels[$];
   int          fail_count = 0;
   int          queued = 0;

   assign errors  = fail_count;
   assign pending = queued;

   function automatic int row_span();
      int h;
      h = $signed(img_h);
      if (h < 0) h = -h;
      if (h > 2047) h = 2047;
      return h;
   endfunction

   // advances the unpacker by one byte, returns 1 when a pixel completes
   function automatic bit unpack_byte(input logic [7:0] b, output pixel_out_type px);
      int rows, width, h, ox, oy, c, r, sx, sy;
      logic [7:0] alpha;
      bit row_end, last, vis;
      px = '0;
      alpha = '0;
      rows = row_span();
      width = img_w;
      if (image_done || rows == 0 || width == 0) return 0;
      if (pad_left != 0) begin
         pad_left = pad_left - 2'd1;
         return 0;
      end
      case (phase)
         bpfb_pkg::PHASE_BLUE: begin
            blue_b = b;
            phase = bpfb_pkg::PHASE_GREEN;
            return 0;
         end
         bpfb_pkg::PHASE_GREEN: begin
            green_b = b;
            phase = bpfb_pkg::PHASE_RED;
            return 0;
         end
         bpfb_pkg::PHASE_RED: begin
            red_b = b;
            if (alpha_en) begin
               phase = bpfb_pkg::PHASE_ALPHA;
               return 0;
            end
         end
         default: begin
            if (alpha_en) alpha = b;
         end
      endcase
      phase = bpfb_pkg::PHASE_BLUE;

      h = $signed(img_h);
      ox = $signed(org_x);
      oy = $signed(org_y);
      c = col;
      r = row;
      sx = ox + c;
      sy = (h > 0) ? oy + h - 1 - r : oy + r;
      vis = sx >= 0 && sx < PANEL_W && sy >= 0 && sy < PANEL_H;
      if (vis) px.addr = bpfb_pkg::FB_ADDR_W'(sy * PANEL_W + sx);
      row_end = c + 1 >= width;
      last = row_end && r + 1 >= rows;
      px.color = {alpha, red_b, green_b, blue_b};
      px.on_screen = vis;
      px.last = last;

      if (last) begin
         image_done = 1'b1;
      end else if (row_end) begin
         col = '0;
         row = row + 11'd1;
         if (!alpha_en) pad_left = 2'(4 - ((3 * width) & 3));
      end else begin
         col = col + 11'd1;
      end
      return 1;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t %s mismatch: expected %0h, got %0h", $realtime, field, want, seen);
      end
   endtask

   always @(posedge clock) begin
      pixel_out_type px;
      if (reset) begin
         org_x = '0;
         org_y = '0;
         img_w = 11'd1;
         img_h = 12'd1;
         alpha_en = 1'b1;
         phase = bpfb_pkg::PHASE_BLUE;
         blue_b = '0;
         green_b = '0;
         red_b = '0;
         col = '0;
         row = '0;
         pad_left = '0;
         image_done = 1'b0;
         pending_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bpfb_pkg::CSR_ORIGIN_X:      org_x = csr_wdata[11:0];
               bpfb_pkg::CSR_ORIGIN_Y:      org_y = csr_wdata[11:0];
               bpfb_pkg::CSR_IMAGE_WIDTH:   img_w = csr_wdata[10:0];
               bpfb_pkg::CSR_IMAGE_HEIGHT:  img_h = csr_wdata[11:0];
               bpfb_pkg::CSR_ALPHA_PRESENT: alpha_en = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (unpack_byte(req_tdata, px)) pending_pixels.push_back(px);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected pixel beat: data %0h user %0b last %0b",
                           $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               px = pending_pixels.pop_front();
               check_field("fb_address", 32'(px.addr), 32'(rsp_tdata[18:0]));
               check_field("pixel_color", px.color, rsp_tdata[50:19]);
               check_field("zero fill", 32'd0, 32'(rsp_tdata[55:51]));
               check_field("on_screen", 32'(px.on_screen), 32'(rsp_tuser));
               check_field("last_pixel", 32'(px.last), 32'(rsp_tlast));
            end
         end
      end
      queued = pending_pixels.size();
   end

endmodule

// ===== bench/tb_bmp_pixel_array_to_framebuffer_unit.sv =====
module tb_bmp_pixel_array_to_framebuffer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PANEL_W = 800;
   localparam int PANEL_H = 480;
   localparam int BYTE_TARGET = 1450;

   typedef enum {PACE_FULL, PACE_SLOW_SRC, PACE_SLOW_SINK, PACE_LIGHT} pace_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [bpfb_pkg::CSR_IDX_W-1:0]  csr_index = bpfb_pkg::CSR_ORIGIN_X;
   logic [bpfb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int bytes_sent = 0;
   int fail_count;
   int queued;

   bmp_pixel_array_to_framebuffer_unit #(
      .PANEL_WIDTH(PANEL_W),
      .PANEL_HEIGHT(PANEL_H)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   bmp_unpack_checker #(
      .PANEL_W(PANEL_W),
      .PANEL_H(PANEL_H)
   ) chk (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .errors(fail_count),
      .pending(queued)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_FULL: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         PACE_SLOW_SRC: begin
            send_idle_pct = 86;
            rsp_stall_pct = 0;
         end
         PACE_SLOW_SINK: begin
            send_idle_pct = 0;
            rsp_stall_pct = 86;
         end
         default: begin
            send_idle_pct = 6;
            rsp_stall_pct = 6;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // stop sending and wait until every predicted pixel has drained
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (queued != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input bpfb_pkg::csr_index_type idx,
                            input logic [bpfb_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(input int ox, input int oy, input int w, input int h,
                               input bit a);
      write_csr(bpfb_pkg::CSR_ORIGIN_X, 12'(ox));
      write_csr(bpfb_pkg::CSR_ORIGIN_Y, 12'(oy));
      write_csr(bpfb_pkg::CSR_IMAGE_WIDTH, {1'($urandom_range(1)), 11'(w)});
      write_csr(bpfb_pkg::CSR_IMAGE_HEIGHT, 12'(h));
      write_csr(bpfb_pkg::CSR_ALPHA_PRESENT, {11'($urandom), a});
      csr_we <= 1'b0;
   endtask

   initial begin
      int ox, oy, w, h, hmag, seg_len;
      bit a;
      logic [7:0] seed_bytes[8];

      seed_bytes = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h55, 8'hAA};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tallest top-down image, first pixels in the corner
      set_pace(PACE_FULL);
      program_regs(0, 0, 2047, -2048, 1'b1);
      foreach (seed_bytes[i]) send_byte(seed_bytes[i]);

      // zero width, then zero height: nothing comes out
      settle();
      program_regs(799, 479, 0, -2048, 1'b1);
      send_byte(8'hFF);
      send_byte(8'h00);
      settle();
      program_regs(-1, 479, 2047, 0, 1'b1);
      send_byte(8'h5A);
      send_byte(8'hA5);

      // far corner, bottom-up, alpha dropped while the alpha byte is due
      settle();
      set_pace(PACE_SLOW_SINK);
      program_regs(2047, -2048, 2047, 2047, 1'b1);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      settle();
      write_csr(bpfb_pkg::CSR_ALPHA_PRESENT, '0);
      csr_we <= 1'b0;
      send_byte(8'h78);

      // width shrunk under the column count, 24-bit row padding, right edge
      settle();
      set_pace(PACE_SLOW_SRC);
      program_regs(796, 0, 3, -1200, 1'b0);
      repeat (9) send_byte(pick_byte());

      while (bytes_sent < BYTE_TARGET - 24) begin
         settle();
         set_pace(pace_type'($urandom_range(3)));
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(7))
               0: ox = -2048;
               1: ox = 2047;
               default: ox = int'($urandom_range(900)) - 100;
            endcase
            case ($urandom_range(7))
               0: w = 2047;
               1: w = $urandom_range(2047, 1);
               default: w = $urandom_range(12, 1);
            endcase
            hmag = $urandom_range(2047, 600);
            if ($urandom_range(9) == 0) begin
               h = -2048;
               hmag = 2047;
            end else begin
               h = $urandom_range(1) ? -hmag : hmag;
            end
            if (h < 0) oy = int'($urandom_range(900)) - 500;
            else oy = 1 - hmag + int'($urandom_range(900)) - 100;
            if (oy < -2048) oy = -2048;
            case ($urandom_range(9))
               0: oy = -2048;
               1: oy = 2047;
               default: ;
            endcase
            a = $urandom_range(1);
            program_regs(ox, oy, w, h, a);
         end
         seg_len = $urandom_range(64, 16);
         repeat (seg_len) send_byte(pick_byte());
      end

      // one-row image ends at the next row end, trailing bytes are swallowed
      settle();
      set_pace(pace_type'($urandom_range(3)));
      program_regs(int'($urandom_range(900)) - 100, int'($urandom_range(500)) - 10,
                   $urandom_range(3, 1), $urandom_range(1) ? -1 : 1, 1'($urandom_range(1)));
      repeat (24) send_byte(pick_byte());

      settle();
      if (fail_count == 0 && queued == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/bpfb_pkg.sv
src/bpfb_locate.sv
src/bmp_pixel_array_to_framebuffer_unit.sv
bench/bmp_unpack_checker.sv
bench/tb_bmp_pixel_array_to_framebuffer_unit.sv
